>>> rtl/core/sha256_pkg.sv
// SHA-256 types, constants and round functions shared by the hasher.
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Request action codes
  localparam logic [1:0] ACT_ABSORB  = 2'd0;
  localparam logic [1:0] ACT_FINISH  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam word_t INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return g ^ (e & (f ^ g));
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return ((a | b) & c) | (a & b);
  endfunction

endpackage

>>> rtl/core/sha256_message_hasher.sv
// SHA-256 hasher top level: byte intake, padding, round sequencer and digest readout.
//
// Takes one request per accepted item: absorb a message byte, finish (pad and read out
// the digest) or restart (reload the initial hash, clear counts). Absorbed bytes go into a
// 16-word block buffer at one byte per cycle while idle. The byte that completes a
// 64-byte block starts a compression on a single shared round unit: a load step, 64
// round steps (one round and one schedule word each) and a feed-forward step, with
// the input stalled until it ends. Finish takes a padding step and a length step,
// then a compression, then eight digest words, one per cycle when the receiver does
// not stall. When the message leaves fewer than nine free bytes in the block, padding
// needs a second block: the first is compressed, then cleared before the length step
// and a second compression. Digest words come out big-endian, word 0 first, last_word
// set on word 7. Finish does not reinitialise the hash; send restart to begin a new
// message. The bit count wraps modulo 2^64. Action code 3 is accepted and ignored.
module sha256_message_hasher (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::word_t     out_digest_word,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word
);
  import sha256_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;  // 0x80 marker and trailing zeros
  localparam logic [2:0] ST_ZERO  = 3'd2;  // clear second padding block
  localparam logic [2:0] ST_LEN   = 3'd3;  // bit length into words 14/15
  localparam logic [2:0] ST_INIT  = 3'd4;  // load working vars
  localparam logic [2:0] ST_ROUND = 3'd5;
  localparam logic [2:0] ST_FF    = 3'd6;  // feed-forward into chain
  localparam logic [2:0] ST_OUT   = 3'd7;

  // Where to go once a compression ends
  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_ZERO = 2'd1;
  localparam logic [1:0] RET_OUT  = 2'd2;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  ret_r, ret_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;

  word_t chain_r [8];
  word_t vars_r  [8];
  word_t sched_r [16];   // rolling window, [15] newest
  word_t blk_r   [16];   // block buffer, byte 0 in word 0 bits 31:24

  logic        out_valid_r;
  word_t       out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  logic        in_acc;
  logic        out_load;
  word_t       w_cur, t1, t2;

  assign in_stall        = (state_r != ST_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;
  assign out_load        = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Shared round unit
  always_comb begin
    if (rnd_r < 6'd16) begin
      w_cur = blk_r[rnd_r[3:0]];
    end else begin
      w_cur = small_sigma1(sched_r[14]) + sched_r[9] + small_sigma0(sched_r[1]) + sched_r[0];
    end
    t1 = vars_r[7] + big_sigma1(vars_r[4]) + choose(vars_r[4], vars_r[5], vars_r[6])
       + ROUND_K[rnd_r] + w_cur;
    t2 = big_sigma0(vars_r[0]) + majority(vars_r[0], vars_r[1], vars_r[2]);
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    fill_nxt   = fill_r;
    bitlen_nxt = bitlen_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_ABSORB: begin
              fill_nxt = fill_r + 6'd1;
              if (fill_r == 6'd63) begin
                bitlen_nxt = bitlen_r + 64'd512;
                ret_nxt    = RET_IDLE;
                state_nxt  = ST_INIT;
              end
            end
            ACT_FINISH: state_nxt = ST_PAD;
            ACT_RESTART: begin
              fill_nxt   = '0;
              bitlen_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        bitlen_nxt = bitlen_r + {55'd0, fill_r, 3'b000};
        if (fill_r >= 6'd56) begin
          fill_nxt  = '0;
          ret_nxt   = RET_ZERO;
          state_nxt = ST_INIT;
        end else begin
          fill_nxt  = fill_r + 6'd1;
          state_nxt = ST_LEN;
        end
      end
      ST_ZERO: state_nxt = ST_LEN;
      ST_LEN: begin
        ret_nxt   = RET_OUT;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_FF;
      end
      ST_FF: begin
        idx_nxt = '0;
        case (ret_r)
          RET_ZERO: state_nxt = ST_ZERO;
          RET_OUT:  state_nxt = ST_OUT;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= RET_IDLE;
      fill_r   <= '0;
      bitlen_r <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      fill_r   <= fill_nxt;
      bitlen_r <= bitlen_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= INIT_HASH[i];
    end else if (in_acc && in_action == ACT_RESTART) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= INIT_HASH[i];
    end else if (state_r == ST_FF) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + vars_r[i];
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk) begin
    if (state_r == ST_INIT) begin
      for (int i = 0; i < 8; i++) vars_r[i] <= chain_r[i];
    end else if (state_r == ST_ROUND) begin
      vars_r[0] <= t1 + t2;
      vars_r[1] <= vars_r[0];
      vars_r[2] <= vars_r[1];
      vars_r[3] <= vars_r[2];
      vars_r[4] <= vars_r[3] + t1;
      vars_r[5] <= vars_r[4];
      vars_r[6] <= vars_r[5];
      vars_r[7] <= vars_r[6];
      for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i+1];
      sched_r[15] <= w_cur;
    end
  end

  // Block buffer: byte writes, padding, length
  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_ABSORB) begin
      for (int j = 0; j < 16; j++) begin
        for (int b = 0; b < 4; b++) begin
          if (fill_r == {j[3:0], b[1:0]}) blk_r[j][8*(3-b) +: 8] <= in_data_byte;
        end
      end
    end else if (state_r == ST_PAD) begin
      for (int j = 0; j < 16; j++) begin
        for (int b = 0; b < 4; b++) begin
          if (fill_r == {j[3:0], b[1:0]}) begin
            blk_r[j][8*(3-b) +: 8] <= 8'h80;
          end else if ({j[3:0], b[1:0]} > fill_r) begin
            blk_r[j][8*(3-b) +: 8] <= 8'h00;
          end
        end
      end
    end else if (state_r == ST_ZERO) begin
      for (int j = 0; j < 14; j++) blk_r[j] <= '0;
    end else if (state_r == ST_LEN) begin
      blk_r[14] <= bitlen_r[63:32];
      blk_r[15] <= bitlen_r[31:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= chain_r[idx_r];
      out_idx_r  <= idx_r;
      out_last_r <= (idx_r == 3'd7);
    end
  end

  // Checks
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_FF && rnd_r == 6'd0))
    else $error("round counter and sequencer out of step");

  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words not delivered in order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last word flag mismatch");

endmodule

>>> bench/tb_sha256_message_hasher.sv
// Self-checking bench for the SHA-256 message hasher: digest prediction and stall-driven traffic.
`timescale 1ns / 1ps

module tb_sha256_message_hasher;
  import sha256_pkg::*;

  // Action code that the block must swallow without effect
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Generous wall-clock limit in ns, against an 8 ns clock period
  localparam int unsigned RUN_LIMIT_NS = 8_000_000;

  // FIPS 180-4 initial hash value and round constants, held locally
  localparam word_t HASH_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t ROUND_CONST [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // One digest word as the result channel should present it
  typedef struct packed {
    word_t      word;
    logic [2:0] pos;
    logic       is_last;
  } digest_entry_t;

  // Shadow of the hasher: chaining value, block buffer, byte fill and bit count.
  // Every accepted request is replayed here; finish pushes the eight words due.
  class running_digest;
    word_t           chain [8];
    logic [7:0]      block [64];
    int unsigned     fill;
    logic [63:0]     msg_bits;
    digest_entry_t   due_words [$];
    int unsigned     mismatches;
    int unsigned     words_noted;
    int unsigned     digests;
    int unsigned     two_block_pads;

    function new();
      reload();
      foreach (block[i]) block[i] = 8'h00;
      mismatches = 0;
      words_noted = 0;
      digests = 0;
      two_block_pads = 0;
    endfunction

    function void reload();
      chain = HASH_IV;
      fill = 0;
      msg_bits = '0;
    endfunction

    function word_t rotr(word_t x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Full 64-word schedule, 64 rounds, feed-forward into the chain
    function void compress();
      word_t sched [64];
      word_t v [8];
      word_t s0, s1, t1, t2;
      for (int t = 0; t < 16; t++)
        sched[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
        s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
        sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + sched[t];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void note_request(logic [1:0] action, logic [7:0] data);
      case (action)
        ACT_ABSORB: begin
          block[fill] = data;
          fill++;
          if (fill == 64) begin
            compress();
            msg_bits += 64'd512;
            fill = 0;
          end
        end
        ACT_RESTART: reload();
        ACT_FINISH: begin
          // pad in place; state is left as padding leaves it
          msg_bits += 64'(fill) << 3;
          block[fill] = 8'h80;
          fill++;
          if (fill > 56) begin
            for (int i = fill; i < 64; i++) block[i] = 8'h00;
            compress();
            fill = 0;
            two_block_pads++;
          end
          for (int i = fill; i < 56; i++) block[i] = 8'h00;
          for (int i = 0; i < 8; i++) block[56+i] = msg_bits[63-8*i -: 8];
          compress();
          for (int i = 0; i < 8; i++)
            due_words.push_back('{word: chain[i], pos: 3'(i), is_last: (i == 7)});
          words_noted += 8;
          digests++;
        end
        default: ;
      endcase
    endfunction

    function void check_word(word_t word, logic [2:0] pos, logic is_last);
      digest_entry_t want;
      if (due_words.size() == 0) begin
        $error("digest_word: none expected, actual %h", word);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      if (word !== want.word) begin
        $error("digest_word: expected %h, actual %h", want.word, word);
        mismatches++;
      end
      if (pos !== want.pos) begin
        $error("word_index: expected %0d, actual %0d", want.pos, pos);
        mismatches++;
      end
      if (is_last !== want.is_last) begin
        $error("last_word: expected %0b, actual %0b", want.is_last, is_last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = ACT_ABSORB;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  word_t      out_digest_word;
  logic [2:0] out_word_index;
  logic       out_last_word;

  running_digest digest_state = new();

  // Idling controls: percentage odds of a sender gap before a request, and per-cycle
  // odds of the receiver starting a stall burst. Zero means that side never idles.
  int unsigned gap_odds = 0;
  int unsigned stall_odds = 0;
  int unsigned stall_left = 0;
  int unsigned item_count = 0;
  int unsigned ignored_count = 0;
  bit          drained_once = 1'b0;

  sha256_message_hasher i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always #4 clk = ~clk;

  // Receiver: random stall bursts, started at random while enabled
  always @(posedge clk) begin
    if (stall_left == 0 && stall_odds != 0 && $urandom_range(0, 99) < stall_odds)
      stall_left = $urandom_range(1, 11);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor. Sampled at the edge, so both sides see pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      digest_state.check_word(out_digest_word, out_word_index, out_last_word);
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // Present one request and hold it until the block takes it. An optional gap
  // beforehand drops valid and scribbles on the payload. Valid is never lowered
  // here after acceptance, so back-to-back requests keep it high.
  task automatic send_request(input logic [1:0] action, input logic [7:0] data);
    if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
      in_valid <= 1'b0;
      in_action <= 2'($urandom);
      in_data_byte <= 8'($urandom);
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    digest_state.note_request(action, data);
    if (action == ACT_UNUSED)
      ignored_count++;
    else
      item_count++;
  endtask

  // Hold off the sender until every outstanding digest word has been seen.
  // Valid is only dropped when there is something to wait for, so the next
  // request never lands in the same step.
  task automatic wait_for_digests();
    if (digest_state.due_words.size() != 0) begin
      in_valid <= 1'b0;
      while (digest_state.due_words.size() != 0) @(posedge clk);
    end
  endtask

  // Message lengths lean towards short ones and the 55/56 padding boundary,
  // with a few that run past one full block
  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(0, 12);
    if (roll < 75) return $urandom_range(52, 66);
    if (roll < 90) return $urandom_range(13, 51);
    return $urandom_range(67, 130);
  endfunction

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_request(ACT_ABSORB, 8'($urandom));
    send_request(ACT_FINISH, 8'($urandom));
  endtask

  initial begin
    int unsigned roll;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty message, finish straight after finish, a short
    // known message, byte extremes, the ignored code and an abandoned message.
    stall_odds = 10;
    send_request(ACT_FINISH, 8'h00);
    send_request(ACT_FINISH, 8'hFF);
    send_request(ACT_RESTART, 8'h5A);
    send_request(ACT_ABSORB, 8'h61);
    send_request(ACT_ABSORB, 8'h62);
    send_request(ACT_ABSORB, 8'h63);
    send_request(ACT_FINISH, 8'h00);
    send_request(ACT_ABSORB, 8'h00);
    send_request(ACT_ABSORB, 8'hFF);
    send_request(ACT_UNUSED, 8'hA5);
    send_request(ACT_FINISH, 8'h00);
    send_request(ACT_RESTART, 8'h00);
    send_request(ACT_UNUSED, 8'h00);
    send_request(ACT_ABSORB, 8'hFF);
    send_request(ACT_RESTART, 8'hFF);
    send_request(ACT_ABSORB, 8'h80);
    send_request(ACT_FINISH, 8'hC3);

    // Random part: mostly clean restart/absorb/finish messages, with some
    // continuation after finish, abandoned messages, bare finishes and noise.
    while (item_count < 280 || digest_state.words_noted < 48) begin
      if (item_count >= 240) begin
        // settle into the tail with no idling on either side
        gap_odds = 0;
        stall_odds = 0;
      end else if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: begin gap_odds = 0;  stall_odds = 0;  end
          1: begin gap_odds = 15; stall_odds = 6;  end
          default: begin gap_odds = 40; stall_odds = 15; end
        endcase
      end

      if (!drained_once && item_count >= 150 && digest_state.due_words.size() != 0) begin
        wait_for_digests();
        drained_once = 1'b1;
      end

      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_request(ACT_RESTART, 8'($urandom));
        send_message(pick_length());
      end else if (roll < 80) begin
        send_message(pick_length());
      end else if (roll < 88) begin
        for (int unsigned i = pick_length() / 2; i != 0; i--)
          send_request(ACT_ABSORB, 8'($urandom));
        send_request(ACT_RESTART, 8'($urandom));
      end else if (roll < 94) begin
        send_request(ACT_UNUSED, 8'($urandom));
      end else begin
        send_request(ACT_FINISH, 8'($urandom));
      end
    end

    // Drain, then keep running so that a stray digest word would still be caught
    wait_for_digests();
    repeat (160) @(posedge clk);

    $display("Covered %0d requests plus %0d with the unused code; %0d digests checked,",
             item_count, ignored_count, digest_state.digests);
    $display("%0d of them padded over two blocks, under random gaps and stalls.",
             digest_state.two_block_pads);
    if (digest_state.mismatches == 0 && digest_state.due_words.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
